[hdl/tcw_pkg.sv]
package tcw_pkg;

  // character codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;

  // attribute used by the clear that follows reset
  localparam logic [7:0] RESET_COLOR = 8'h07;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PUT,
    ST_LOAD
  } state_t;

  // decoded kind of the held item
  typedef enum logic [2:0] {
    KIND_READ,
    KIND_NL,
    KIND_CR,
    KIND_TAB,
    KIND_CHAR
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic ld_item;   // capture the input item
    logic rd_issue;  // read the addressed cell
    logic step;      // one cursor step of a put
    logic clr_step;  // write one cell of the clearing pass
    logic load_out;  // load the result register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic wrap_clr;        // current step reaches the row limit
    logic tab_more_now;    // tab has spaces left after this step
    logic tab_more_after;  // tab has spaces left after a clear
    logic clr_last;        // clearing pass at its last cell
    logic item_act;        // an item is in flight
    logic out_free;        // result register can take a new result
  } ctl_sts_t;

endpackage

[hdl/tcw_ctrl.sv]
module tcw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_stall,
  input  tcw_pkg::ctl_sts_t  sts,
  output tcw_pkg::ctl_cmd_t  cmd
);
  import tcw_pkg::*;

  state_t state_r, state_nxt;

  // state register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          if (!sts.item_act) begin
            state_nxt = ST_IDLE;
          end else if (sts.tab_more_after) begin
            state_nxt = ST_PUT;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_cmd ? ST_READ : ST_PUT;
        end
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_PUT: begin
        if (sts.wrap_clr) begin
          state_nxt = ST_CLEAR;
        end else if (!sts.tab_more_now) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.ld_item = in_valid;
      end
      ST_READ: cmd.rd_issue = 1'b1;
      ST_PUT:  cmd.step = 1'b1;
      ST_LOAD: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

[hdl/tcw_dpath.sv]
module tcw_dpath #(
  parameter int COLS       = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::ctl_cmd_t  cmd,
  output tcw_pkg::ctl_sts_t  sts,
  input  logic               in_cmd,
  input  logic [7:0]         in_ch,
  input  logic [6:0]         in_rd_col,
  input  logic [4:0]         in_rd_row,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_cell_char,
  output logic [7:0]         out_cell_color,
  output logic [6:0]         out_cursor_col,
  output logic [4:0]         out_cursor_row,
  output logic               out_cleared
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TW    = $clog2(TAB_SPACES + 1);

  localparam logic [AW-1:0] COLS_A    = AW'(COLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [TW-1:0] TAB_LAST  = TW'(TAB_SPACES - 1);
  localparam logic [TW-1:0] TAB_ALL   = TW'(TAB_SPACES);

  // character store; every cell shares the attribute of the last clear
  logic [7:0] char_mem [CELLS];

  // held item
  logic       cmd_r;
  logic [7:0] ch_r;
  logic [6:0] rd_col_r;
  logic [4:0] rd_row_r;

  // control state
  logic [CW-1:0] cur_x_r, cur_x_nxt;
  logic [RW-1:0] cur_y_r, cur_y_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [TW-1:0] tab_cnt_r, tab_cnt_nxt;
  logic [7:0]    clr_color_r, clr_color_nxt;
  logic [7:0]    dflt_color_r;
  logic          cleared_r, cleared_nxt;
  logic          item_act_r;
  logic          out_valid_r;

  // payload
  logic [7:0] rdata_r;
  logic [7:0] o_char_r, o_color_r;
  logic [6:0] o_col_r;
  logic [4:0] o_row_r;
  logic       o_clr_r;

  kind_t         kind;
  logic          last_col, last_row, wrap_clr, rd_ok, emit;
  logic [AW-1:0] rd_addr, wr_addr, mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_we;
  logic [8:0]    x_ext;
  logic [6:0]    y_ext;

  // item decode
  always_comb begin
    if (cmd_r) begin
      kind = KIND_READ;
    end else begin
      case (ch_r)
        CH_NEWLINE: kind = KIND_NL;
        CH_RETURN:  kind = KIND_CR;
        CH_TAB:     kind = KIND_TAB;
        default:    kind = KIND_CHAR;
      endcase
    end
  end

  assign emit     = (kind == KIND_CHAR) || (kind == KIND_TAB);
  assign last_col = (cur_x_r == LAST_COL);
  assign last_row = (cur_y_r == LAST_ROW);
  assign wrap_clr = last_row && ((kind == KIND_NL) || (emit && last_col));

  // read address and range check
  assign rd_ok   = (9'(rd_col_r) < 9'(COLS)) && (7'(rd_row_r) < 7'(ROWS));
  assign rd_addr = AW'(rd_row_r) * COLS_A + AW'(rd_col_r);
  assign wr_addr = base_r + AW'(cur_x_r);

  // single write port: clearing pass or put
  assign mem_we    = cmd.clr_step || (cmd.step && emit);
  assign mem_waddr = cmd.clr_step ? clr_cnt_r : wr_addr;
  assign mem_wdata = (cmd.clr_step || (kind == KIND_TAB)) ? CH_SPACE : ch_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      char_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_issue) begin
      rdata_r <= char_mem[rd_addr];
    end
  end

  // cursor, clear and tab sequencing
  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    base_nxt      = base_r;
    clr_cnt_nxt   = clr_cnt_r;
    tab_cnt_nxt   = tab_cnt_r;
    clr_color_nxt = clr_color_r;
    cleared_nxt   = cleared_r;

    if (cmd.clr_step) begin
      clr_cnt_nxt = (clr_cnt_r == LAST_CELL) ? '0 : clr_cnt_r + 1'b1;
    end

    if (cmd.ld_item) begin
      tab_cnt_nxt = '0;
      cleared_nxt = 1'b0;
    end

    if (cmd.step) begin
      if (kind == KIND_TAB) begin
        tab_cnt_nxt = tab_cnt_r + 1'b1;
      end
      if (wrap_clr) begin
        // row limit: home the cursor and start the clearing pass
        cur_x_nxt     = '0;
        cur_y_nxt     = '0;
        base_nxt      = '0;
        clr_cnt_nxt   = '0;
        clr_color_nxt = dflt_color_r;
        cleared_nxt   = 1'b1;
      end else begin
        case (kind)
          KIND_NL: begin
            cur_x_nxt = '0;
            cur_y_nxt = cur_y_r + 1'b1;
            base_nxt  = base_r + COLS_A;
          end
          KIND_CR: cur_x_nxt = '0;
          KIND_CHAR, KIND_TAB: begin
            if (last_col) begin
              cur_x_nxt = '0;
              cur_y_nxt = cur_y_r + 1'b1;
              base_nxt  = base_r + COLS_A;
            end else begin
              cur_x_nxt = cur_x_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      base_r       <= '0;
      clr_cnt_r    <= '0;
      tab_cnt_r    <= '0;
      clr_color_r  <= RESET_COLOR;
      dflt_color_r <= RESET_COLOR;
      cleared_r    <= 1'b0;
      item_act_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      base_r      <= base_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      tab_cnt_r   <= tab_cnt_nxt;
      clr_color_r <= clr_color_nxt;
      cleared_r   <= cleared_nxt;
      if (cfg_wr_en) begin
        dflt_color_r <= cfg_wr_data;
      end
      if (cmd.ld_item) begin
        item_act_r <= 1'b1;
      end else if (cmd.load_out) begin
        item_act_r <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      cmd_r    <= in_cmd;
      ch_r     <= in_ch;
      rd_col_r <= in_rd_col;
      rd_row_r <= in_rd_row;
    end
  end

  // result register
  assign x_ext = 9'(cur_x_r);
  assign y_ext = 7'(cur_y_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_char_r  <= ((kind == KIND_READ) && rd_ok) ? rdata_r : 8'h00;
      o_color_r <= ((kind == KIND_READ) && rd_ok) ? clr_color_r : 8'h00;
      o_col_r   <= x_ext[6:0];
      o_row_r   <= y_ext[4:0];
      o_clr_r   <= cleared_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_char  = o_char_r;
  assign out_cell_color = o_color_r;
  assign out_cursor_col = o_col_r;
  assign out_cursor_row = o_row_r;
  assign out_cleared    = o_clr_r;

  // status
  assign sts.wrap_clr       = wrap_clr;
  assign sts.tab_more_now   = (kind == KIND_TAB) && (tab_cnt_r != TAB_LAST);
  assign sts.tab_more_after = (kind == KIND_TAB) && (tab_cnt_r != TAB_ALL);
  assign sts.clr_last       = (clr_cnt_r == LAST_CELL);
  assign sts.item_act       = item_act_r;
  assign sts.out_free       = !out_valid_r || !out_stall;

endmodule

[hdl/text_console_writer_unit.sv]
// Each item is taken in idle, then read or put (a tab puts TAB_SPACES spaces) and
// loaded into the result register; any clear writes one cell per cycle (one write port).
// A new item is taken only after the last one is loaded, bound by the single
// controller sequencing each item; result register frees the input side.
// Reset (rst_n low, synchronous): cursor homed, default color 7, then a
// clearing pass during which no input is taken.
module text_console_writer_unit #(
  parameter int COLS       = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_ch,
  input  logic [6:0] in_rd_col,
  input  logic [4:0] in_rd_row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_color,
  output logic [6:0] out_cursor_col,
  output logic [4:0] out_cursor_row,
  output logic       out_cleared,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import tcw_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_dpath #(
    .COLS       (COLS),
    .ROWS       (ROWS),
    .TAB_SPACES (TAB_SPACES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_cmd         (in_cmd),
    .in_ch          (in_ch),
    .in_rd_col      (in_rd_col),
    .in_rd_row      (in_rd_row),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_char  (out_cell_char),
    .out_cell_color (out_cell_color),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cleared    (out_cleared)
  );

`ifndef SYNTH
  // a loaded result shows up on the output
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  // clearing pass runs without a gap until its last cell
  a_clr_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clr_step && !sts.clr_last) |=> cmd.clr_step)
    else $error("clearing pass interrupted");

  // reaching the row limit starts the clearing pass
  a_wrap_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.wrap_clr) |=> cmd.clr_step)
    else $error("row limit did not start a clear");

  // no input transfer during a clear, a put step or a read
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clr_step || cmd.step || cmd.rd_issue) |-> in_stall)
    else $error("input taken while busy");
`endif

endmodule

[sim/text_console_writer_unit_test.sv]
`timescale 1ns / 1ps

module text_console_writer_unit_test;
  import tcw_pkg::*;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 4;
  localparam int CELLS      = COLS * ROWS;

  localparam int PHASE_ITEMS  = 290;
  localparam int N_PHASES     = 5;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_WAIT    = 8;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int MAX_SHOWN    = 10;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    logic [6:0] rd_col;
    logic [4:0] rd_row;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       cleared;
  } cell_rsp_t;

  typedef struct packed {
    cmd_item_t it;
    logic      typed;
    cell_rsp_t rsp;
  } dir_row_t;

  typedef enum int {
    SEQ_TEXT,
    SEQ_LINES,
    SEQ_READ,
    SEQ_TABS,
    SEQ_FILL,
    SEQ_NOISE
  } seq_kind_t;

  // directed rows: typed response only where it is obvious
  localparam int N_DIR = 22;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{'{CMD_READ, 8'h00, 7'd0,   5'd0},  1'b1, '{CH_SPACE, RESET_COLOR, 7'd0, 5'd0, 1'b0}},
    '{'{CMD_READ, 8'hFF, 7'd79,  5'd24}, 1'b1, '{CH_SPACE, RESET_COLOR, 7'd0, 5'd0, 1'b0}},
    '{'{CMD_READ, 8'h00, 7'd80,  5'd0},  1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
    '{'{CMD_READ, 8'h00, 7'd0,   5'd25}, 1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
    '{'{CMD_READ, 8'hFF, 7'd127, 5'd31}, 1'b1, '{8'h00, 8'h00, 7'd0, 5'd0, 1'b0}},
    '{'{CMD_PUT,  8'h41, 7'd127, 5'd31}, 1'b1, '{8'h00, 8'h00, 7'd1, 5'd0, 1'b0}},
    '{'{CMD_PUT,  8'h00, 7'd0,   5'd0},  1'b0, '0},
    '{'{CMD_PUT,  8'hFF, 7'd5,   5'd3},  1'b0, '0},
    '{'{CMD_READ, 8'h00, 7'd0,   5'd0},  1'b0, '0},
    '{'{CMD_READ, 8'h00, 7'd2,   5'd0},  1'b0, '0},
    '{'{CMD_PUT,  CH_TAB, 7'd0,  5'd0},  1'b0, '0},
    '{'{CMD_READ, 8'h00, 7'd3,   5'd0},  1'b0, '0},
    '{'{CMD_PUT,  CH_RETURN, 7'd0, 5'd0}, 1'b0, '0},
    '{'{CMD_PUT,  CH_NEWLINE, 7'd0, 5'd0}, 1'b0, '0},
    '{'{CMD_PUT,  CH_NEWLINE, 7'd0, 5'd0}, 1'b0, '0},
    '{'{CMD_PUT,  8'h7E, 7'd0,   5'd0},  1'b0, '0},
    '{'{CMD_READ, 8'h00, 7'd0,   5'd2},  1'b0, '0},
    '{'{CMD_PUT,  CH_SPACE, 7'd0, 5'd0}, 1'b0, '0},
    '{'{CMD_PUT,  CH_RETURN, 7'd0, 5'd0}, 1'b0, '0},
    '{'{CMD_READ, 8'h00, 7'd79,  5'd0},  1'b0, '0},
    '{'{CMD_READ, 8'h00, 7'd0,   5'd1},  1'b0, '0},
    '{'{CMD_READ, 8'h00, 7'd126, 5'd24}, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_cmd = 1'b0;
  logic [7:0] in_ch = 8'h00;
  logic [6:0] in_rd_col = 7'd0;
  logic [4:0] in_rd_row = 5'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_cell_char;
  logic [7:0] out_cell_color;
  logic [6:0] out_cursor_col;
  logic [4:0] out_cursor_row;
  logic       out_cleared;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  text_console_writer_unit #(
    .COLS(COLS),
    .ROWS(ROWS),
    .TAB_SPACES(TAB_SPACES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_ch(in_ch),
    .in_rd_col(in_rd_col),
    .in_rd_row(in_rd_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cell_char(out_cell_char),
    .out_cell_color(out_cell_color),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .out_cleared(out_cleared),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // screen image and cursor mirrored by the testbench
  logic [7:0]  scr_char [CELLS];
  logic [7:0]  scr_attr [CELLS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0]  clr_attr = RESET_COLOR;

  cell_rsp_t cell_rsp_q [$];
  int        fail_cnt = 0;
  int        sent_cnt = 0;
  int        burst_left = 0;
  seq_kind_t seq_kind = SEQ_TEXT;
  int        seq_left = 0;
  int        fill_target = 0;
  bit        fill_pending = 1'b0;

  function automatic void blank_screen();
    for (int k = 0; k < CELLS; k++) begin
      scr_char[k] = CH_SPACE;
      scr_attr[k] = clr_attr;
    end
    cur_col = 0;
    cur_row = 0;
  endfunction

  // wrap at the right edge, wipe at the bottom; 1 when a wipe happened
  function automatic bit settle_pos();
    if (cur_col >= COLS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      blank_screen();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit type_glyph(input logic [7:0] c);
    if (cur_col < COLS && cur_row < ROWS) scr_char[cur_row * COLS + cur_col] = c;
    cur_col++;
    return settle_pos();
  endfunction

  // expected response of one item; advances the mirrored state
  function automatic cell_rsp_t console_step(input cmd_item_t it);
    cell_rsp_t r;
    bit        clr;
    int        idx;
    r   = '0;
    clr = 1'b0;
    if (it.cmd == CMD_READ) begin
      if (it.rd_col < COLS && it.rd_row < ROWS) begin
        idx          = int'(it.rd_row) * COLS + int'(it.rd_col);
        r.cell_char  = scr_char[idx];
        r.cell_color = scr_attr[idx];
      end
    end else begin
      case (it.ch)
        CH_NEWLINE: begin
          cur_col = 0;
          cur_row++;
          clr = settle_pos();
        end
        CH_RETURN: begin
          cur_col = 0;
          clr = settle_pos();
        end
        CH_TAB: begin
          for (int i = 0; i < TAB_SPACES; i++) begin
            if (type_glyph(CH_SPACE)) clr = 1'b1;
          end
        end
        default: begin
          clr = type_glyph(it.ch);
        end
      endcase
    end
    r.cursor_col = 7'(cur_col);
    r.cursor_row = 5'(cur_row);
    r.cleared    = clr;
    return r;
  endfunction

  // sender gap: mostly short, some long, occasional back-to-back bursts
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // random item generator: mostly console-like sequences, some noise
  function automatic cmd_item_t next_item();
    cmd_item_t it;
    int        r;
    it.cmd    = CMD_PUT;
    it.ch     = 8'($urandom);
    it.rd_col = 7'($urandom);
    it.rd_row = 5'($urandom);
    if (seq_left == 0 || fill_pending) begin
      r = $urandom_range(0, 99);
      if (fill_pending || (r >= 82 && r < 85)) begin
        seq_kind    = SEQ_FILL;
        seq_left    = 10000;
        fill_target = $urandom_range(COLS - TAB_SPACES, COLS - 1);
        fill_pending = 1'b0;
      end else if (r < 38) begin
        seq_kind = SEQ_TEXT;
        seq_left = $urandom_range(1, 90);
      end else if (r < 52) begin
        seq_kind = SEQ_LINES;
        seq_left = $urandom_range(1, 30);
      end else if (r < 72) begin
        seq_kind = SEQ_READ;
        seq_left = $urandom_range(1, 6);
      end else if (r < 82) begin
        seq_kind = SEQ_TABS;
        seq_left = $urandom_range(1, 5);
      end else begin
        seq_kind = SEQ_NOISE;
        seq_left = $urandom_range(1, 4);
      end
    end
    seq_left--;
    r = $urandom_range(0, 99);
    case (seq_kind)
      SEQ_TEXT: begin
        if (r < 85) it.ch = 8'($urandom_range(8'h20, 8'h7E));
      end
      SEQ_LINES: begin
        it.ch = (r < 80) ? CH_NEWLINE : CH_RETURN;
      end
      SEQ_READ: begin
        it.cmd = CMD_READ;
        if (r < 60) begin
          it.rd_col = 7'($urandom_range(0, COLS - 1));
          it.rd_row = 5'($urandom_range(0, ROWS - 1));
        end else if (r < 85) begin
          it.rd_col = 7'($urandom_range(0, COLS - 1));
          it.rd_row = 5'(cur_row);
        end
      end
      SEQ_TABS: begin
        it.ch = (r < 70) ? CH_TAB : ((r < 85) ? CH_RETURN : CH_SPACE);
      end
      SEQ_FILL: begin
        // walk down to the last row, then along it, then a tab off the end
        if (cur_row < ROWS - 1) begin
          it.ch = CH_NEWLINE;
        end else if (cur_col < fill_target) begin
          it.ch = 8'($urandom_range(8'h21, 8'h7E));
        end else begin
          it.ch    = CH_TAB;
          seq_left = 0;
        end
      end
      default: begin
        it.cmd = 1'($urandom);
      end
    endcase
    return it;
  endfunction

  // offer one item, hold it until the transfer, then record its response
  task automatic send_item(input cmd_item_t it, input logic typed, input cell_rsp_t typed_rsp);
    int        gap;
    cell_rsp_t rsp;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= it.cmd;
    in_ch     <= it.ch;
    in_rd_col <= it.rd_col;
    in_rd_row <= it.rd_row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rsp = console_step(it);
    cell_rsp_q.push_back(typed ? typed_rsp : rsp);
    sent_cnt++;
  endtask

  // stimulus and phase control
  initial begin : stim
    logic [7:0] color;
    int         p;
    int         n;
    blank_screen();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < N_DIR; n++) send_item(DIR_TAB[n].it, DIR_TAB[n].typed, DIR_TAB[n].rsp);

    for (p = 0; p < N_PHASES; p++) begin
      // drain, then reprogram the clear attribute while idle
      in_valid <= 1'b0;
      while (cell_rsp_q.size() != 0) @(posedge clk);
      repeat (IDLE_WAIT) @(posedge clk);
      case (p)
        0:       color = 8'h00;
        1:       color = 8'hFF;
        3:       color = 8'h5A;
        default: color = 8'($urandom);
      endcase
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= color;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      clr_attr  = color;

      // each phase opens with a fill walk that ends in a tab off the bottom of the screen
      fill_pending = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) send_item(next_item(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (cell_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && cell_rsp_q.size() == 0) begin
      $display("text_console_writer_unit regression: pass");
    end else begin
      $display("text_console_writer_unit regression: fail");
    end
    $finish;
  end

  // receiver pacing, with long hold-offs to back the block up
  initial begin : rx_pace
    int left;
    int r;
    int holds_done;
    bit stall_now;
    left       = 0;
    holds_done = 0;
    stall_now  = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        if (holds_done < 2 && sent_cnt >= 500 + 600 * holds_done) begin
          holds_done++;
          stall_now = 1'b1;
          left      = HOLD_CYCLES;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            stall_now = 1'b0;
            left      = $urandom_range(1, 8);
          end else if (r < 80) begin
            stall_now = 1'b1;
            left      = $urandom_range(1, 3);
          end else if (r < 90) begin
            stall_now = 1'b1;
            left      = $urandom_range(5, 30);
          end else begin
            stall_now = 1'b0;
            left      = $urandom_range(50, 200);
          end
        end
      end
      left--;
      out_stall <= stall_now;
    end
  end

  // response checker
  always @(posedge clk) begin : rsp_check
    cell_rsp_t got;
    cell_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_cell_char, out_cell_color, out_cursor_col, out_cursor_row, out_cleared};
      if (cell_rsp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_SHOWN)
          $display("unexpected transfer: char %02h color %02h col %0d row %0d clr %0b",
                   got.cell_char, got.cell_color, got.cursor_col, got.cursor_row,
                   got.cleared);
      end else begin
        want = cell_rsp_q.pop_front();
        if (got.cell_char !== want.cell_char || got.cell_color !== want.cell_color ||
            got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
            got.cleared !== want.cleared) begin
          fail_cnt++;
          if (fail_cnt <= MAX_SHOWN)
            $display({"mismatch: exp char %02h color %02h col %0d row %0d clr %0b",
                      " / got char %02h color %02h col %0d row %0d clr %0b"},
                     want.cell_char, want.cell_color, want.cursor_col, want.cursor_row,
                     want.cleared, got.cell_char, got.cell_color, got.cursor_col,
                     got.cursor_row, got.cleared);
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("text_console_writer_unit regression: fail");
    $finish;
  end

endmodule
